// ===== src/pboe_pkg.sv =====
// ----------------------------------------------------------------------------
// pboe_pkg
// Shared constants and types of the PLC bit-operand engine.
// ----------------------------------------------------------------------------
package pboe_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 32;
  localparam int FLAG_W  = 4;

  localparam int FLAG_PULSE = 0;
  localparam int FLAG_SET   = 1;
  localparam int FLAG_RESET = 2;
  localparam int FLAG_EDGE  = 3;

  localparam logic [3:0] ACT_LOAD    = 4'd0;
  localparam logic [3:0] ACT_BEGIN   = 4'd1;
  localparam logic [3:0] ACT_END     = 4'd2;
  localparam logic [3:0] ACT_RDOUT   = 4'd3;
  localparam logic [3:0] ACT_RESOLVE = 4'd4;
  localparam logic [3:0] ACT_RISE    = 4'd5;
  localparam logic [3:0] ACT_FALL    = 4'd6;
  localparam logic [3:0] ACT_SET     = 4'd7;
  localparam logic [3:0] ACT_RESET   = 4'd8;
  localparam logic [3:0] ACT_CONTACT = 4'd9;

  localparam logic [1:0] KIND_IN  = 2'd0;
  localparam logic [1:0] KIND_OUT = 2'd1;
  localparam logic [1:0] KIND_CNT = 2'd2;

  localparam logic REG_RO_MASK   = 1'b0;
  localparam logic REG_DOWN_MASK = 1'b1;

  typedef struct packed {
    logic [3:0]        action;
    logic [1:0]        kind;
    logic [5:0]        idx;
    logic              bit_in;
    logic [BYTE_W-1:0] bits;
    logic [BYTE_W-1:0] edges;
  } item_t;

endpackage

// ===== src/plc_bit_operand_engine_unit.sv =====
// ----------------------------------------------------------------------------
// plc_bit_operand_engine_unit
// Bit-operand store of a PLC scan engine: inputs, outputs and counters.
// ----------------------------------------------------------------------------
// The block takes one command word on the input channel (in_valid_i and
// in_ready_o) and returns exactly one result word on the output channel
// (out_valid_o and out_ready_i). Operand state lives in three memories:
// input rows, output rows and counter entries, each with one read port, one
// write port and a registered read.
// Load, read-out and bit commands read the memories in the accept cycle and
// modify and write back the row in the execute state once the output
// register is free. Begin scan and end scan walk the counter memory one
// entry per cycle, with read and write-back overlapped, and then read the
// addressed counter. One command is in flight at a time.
// A result sits in an output register; while the receiver stalls the
// block still accepts the next command and stops only when that command
// needs the output register.
// Reset clears the memory row valid bits, so all operands read as zero, and
// clears both counter masks. The user must write the masks over the APB port
// only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module plc_bit_operand_engine_unit #(
  parameter int INPUT_BYTES  = 8,
  parameter int OUTPUT_BYTES = 8,
  parameter int COUNTERS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  action_i,
  input  logic [1:0]  operand_kind_i,
  input  logic [5:0]  operand_index_i,
  input  logic        bit_in_i,
  input  logic [7:0]  input_bits_i,
  input  logic [7:0]  input_edges_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        bit_value_o,
  output logic        error_o,
  output logic [7:0]  output_byte_o,
  output logic [31:0] counter_value_o
);

  localparam int BW     = pboe_pkg::BYTE_W;
  localparam int IBW    = (INPUT_BYTES > 1) ? $clog2(INPUT_BYTES) : 1;
  localparam int OBW    = (OUTPUT_BYTES > 1) ? $clog2(OUTPUT_BYTES) : 1;
  localparam int CW     = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
  localparam int WCW    = CW + 1;
  localparam int ROW_W  = 3 * BW;
  localparam int CROW_W = pboe_pkg::FLAG_W + pboe_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_EXEC = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [WCW-1:0] wc_q, wc_d;
  logic           wv_q, wv_d;
  logic [CW-1:0]  wa_q, wa_d;
  pboe_pkg::item_t item_q;
  logic [31:0]    ro_mask_q, down_mask_q;
  logic           out_valid_q, out_valid_d;
  logic           bit_value_q;
  logic           error_q;
  logic [BW-1:0]  output_byte_q;
  logic [31:0]    counter_value_q;

  logic [ROW_W-1:0]  in_mem  [INPUT_BYTES];
  logic [ROW_W-1:0]  out_mem [OUTPUT_BYTES];
  logic [CROW_W-1:0] cnt_mem [COUNTERS];
  logic              in_vld_q  [INPUT_BYTES];
  logic              out_vld_q [OUTPUT_BYTES];
  logic              cnt_vld_q [COUNTERS];
  logic [ROW_W-1:0]  in_rd_q, out_rd_q;
  logic [CROW_W-1:0] cnt_rd_q;
  logic              in_rv_q, out_rv_q, cnt_rv_q;

  logic              in_acc, cfg_we, exec_go, walk_rd;
  logic [IBW-1:0]    in_ra, in_wa;
  logic [OBW-1:0]    out_ra, out_wa;
  logic [CW-1:0]     cnt_ra, cnt_wa;
  logic              cnt_re;
  logic              in_we, out_we, cnt_we, x_cnt_we;
  logic [ROW_W-1:0]  in_wd, out_wd, in_row, out_row;
  logic [CROW_W-1:0] cnt_wd, x_cnt_wd, w_cnt_wd, cnt_row;

  logic [2:0]        bsel;
  logic              di_ok, dq_ok, c_ok, ib_ok, ob_ok;
  logic [BW-1:0]     in_lvl, in_rise, in_fall, o_dir, o_set, o_rst, o_byte;
  logic [BW-1:0]     o_dir_n, o_set_n, o_rst_n;
  logic [3:0]        cf, cf_n, wf, wf_n;
  logic [31:0]       ccount, wcount_n;
  logic              x_err, x_bv;
  logic [BW-1:0]     x_ob;
  logic [31:0]       x_cv;

  assign pready     = 1'b1;
  assign cfg_we     = psel & penable & pwrite;
  assign prdata     = (paddr[2] == pboe_pkg::REG_DOWN_MASK) ? down_mask_q : ro_mask_q;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign exec_go    = (state_q == ST_EXEC) & (~out_valid_q | out_ready_i);
  assign walk_rd    = (state_q == ST_WALK) & (wc_q < WCW'(COUNTERS));

  assign in_ra  = (action_i == pboe_pkg::ACT_LOAD) ? operand_index_i[IBW-1:0]
                                                  : operand_index_i[3 +: IBW];
  assign out_ra = (action_i == pboe_pkg::ACT_RDOUT) ? operand_index_i[OBW-1:0]
                                                   : operand_index_i[3 +: OBW];
  assign in_wa  = (item_q.action == pboe_pkg::ACT_LOAD) ? item_q.idx[IBW-1:0]
                                                       : item_q.idx[3 +: IBW];
  assign out_wa = item_q.idx[3 +: OBW];

  always_comb begin
    cnt_re = 1'b1;
    if (in_acc) begin
      cnt_ra = operand_index_i[CW-1:0];
    end else if (walk_rd) begin
      cnt_ra = wc_q[CW-1:0];
    end else if (state_q == ST_RD) begin
      cnt_ra = item_q.idx[CW-1:0];
    end else begin
      cnt_ra = item_q.idx[CW-1:0];
      cnt_re = 1'b0;
    end
  end

  assign in_row  = in_rv_q ? in_rd_q : '0;
  assign out_row = out_rv_q ? out_rd_q : '0;
  assign cnt_row = cnt_rv_q ? cnt_rd_q : '0;

  // Scan walk: modify the counter entry read in the previous cycle.
  always_comb begin
    wf       = cnt_row[pboe_pkg::COUNT_W +: pboe_pkg::FLAG_W];
    wf_n     = wf;
    wcount_n = cnt_row[pboe_pkg::COUNT_W-1:0];
    if (item_q.action == pboe_pkg::ACT_BEGIN) begin
      if (wf[pboe_pkg::FLAG_SET] | wf[pboe_pkg::FLAG_RESET]) begin
        wf_n[pboe_pkg::FLAG_PULSE] = wf[pboe_pkg::FLAG_SET] & ~wf[pboe_pkg::FLAG_RESET];
      end
    end else if (~ro_mask_q[wa_q] & wf[pboe_pkg::FLAG_PULSE] & wf[pboe_pkg::FLAG_EDGE]) begin
      wcount_n = down_mask_q[wa_q] ? wcount_n - 32'd1 : wcount_n + 32'd1;
      wf_n[pboe_pkg::FLAG_EDGE] = 1'b0;
    end
    w_cnt_wd = {wf_n, wcount_n};
  end

  // Execute stage of one command.
  always_comb begin
    bsel    = item_q.idx[2:0];
    di_ok   = {1'b0, item_q.idx[5:3]} < 4'(INPUT_BYTES);
    dq_ok   = {1'b0, item_q.idx[5:3]} < 4'(OUTPUT_BYTES);
    c_ok    = item_q.idx < 6'(COUNTERS);
    ib_ok   = item_q.idx < 6'(INPUT_BYTES);
    ob_ok   = item_q.idx < 6'(OUTPUT_BYTES);
    in_lvl  = in_row[0 +: BW];
    in_rise = in_row[BW +: BW];
    in_fall = in_row[2*BW +: BW];
    o_dir   = out_row[0 +: BW];
    o_set   = out_row[BW +: BW];
    o_rst   = out_row[2*BW +: BW];
    o_byte  = o_dir | (o_set & ~o_rst);
    cf      = cnt_row[pboe_pkg::COUNT_W +: pboe_pkg::FLAG_W];
    ccount  = cnt_row[pboe_pkg::COUNT_W-1:0];
    o_dir_n = o_dir;
    o_set_n = o_set;
    o_rst_n = o_rst;
    cf_n    = cf;
    x_err   = 1'b0;
    x_bv    = 1'b0;
    x_ob    = '0;
    in_we   = 1'b0;
    out_we  = 1'b0;
    x_cnt_we = 1'b0;
    in_wd   = {~item_q.bits & item_q.edges, item_q.bits & item_q.edges, item_q.bits};
    case (item_q.action) inside
      pboe_pkg::ACT_LOAD: begin
        in_we = ib_ok;
      end
      pboe_pkg::ACT_BEGIN, pboe_pkg::ACT_END: begin
      end
      pboe_pkg::ACT_RDOUT: begin
        x_ob = ob_ok ? o_byte : '0;
      end
      pboe_pkg::ACT_RESOLVE: begin
        case (item_q.kind)
          pboe_pkg::KIND_IN:  x_bv = di_ok & in_lvl[bsel];
          pboe_pkg::KIND_OUT: x_bv = dq_ok & o_byte[bsel];
          pboe_pkg::KIND_CNT: x_bv = c_ok & cf[pboe_pkg::FLAG_PULSE];
          default:            x_err = 1'b1;
        endcase
      end
      pboe_pkg::ACT_RISE, pboe_pkg::ACT_FALL: begin
        if (item_q.kind == pboe_pkg::KIND_IN) begin
          x_bv = di_ok & ((item_q.action == pboe_pkg::ACT_RISE) ? in_rise[bsel]
                                                               : in_fall[bsel]);
        end else if (item_q.kind == pboe_pkg::KIND_CNT) begin
          x_bv = c_ok & cf[pboe_pkg::FLAG_EDGE] &
                 ((item_q.action == pboe_pkg::ACT_RISE) ? cf[pboe_pkg::FLAG_PULSE]
                                                       : ~cf[pboe_pkg::FLAG_PULSE]);
        end else begin
          x_err = 1'b1;
        end
      end
      pboe_pkg::ACT_SET, pboe_pkg::ACT_RESET: begin
        if (item_q.kind == pboe_pkg::KIND_OUT) begin
          out_we = dq_ok;
          o_set_n[bsel] = (item_q.action == pboe_pkg::ACT_SET);
          o_rst_n[bsel] = (item_q.action == pboe_pkg::ACT_RESET);
        end else if (item_q.kind == pboe_pkg::KIND_CNT) begin
          x_cnt_we = c_ok;
          cf_n[pboe_pkg::FLAG_SET]   = (item_q.action == pboe_pkg::ACT_SET);
          cf_n[pboe_pkg::FLAG_RESET] = (item_q.action == pboe_pkg::ACT_RESET);
          if ((cf_n[pboe_pkg::FLAG_SET] & ~cf[pboe_pkg::FLAG_PULSE]) |
              (cf_n[pboe_pkg::FLAG_RESET] & cf[pboe_pkg::FLAG_PULSE])) begin
            cf_n[pboe_pkg::FLAG_EDGE] = 1'b1;
          end
        end else begin
          x_err = 1'b1;
        end
      end
      pboe_pkg::ACT_CONTACT: begin
        if (item_q.kind == pboe_pkg::KIND_OUT) begin
          out_we = dq_ok;
          o_dir_n[bsel] = item_q.bit_in;
        end else if (item_q.kind == pboe_pkg::KIND_CNT) begin
          x_cnt_we = c_ok;
          cf_n[pboe_pkg::FLAG_PULSE] = item_q.bit_in;
          cf_n[pboe_pkg::FLAG_EDGE]  = cf[pboe_pkg::FLAG_PULSE] ^ item_q.bit_in;
        end else begin
          x_err = 1'b1;
        end
      end
      default: begin
        x_err = 1'b1;
      end
    endcase
    out_wd   = {o_rst_n, o_set_n, o_dir_n};
    x_cnt_wd = {cf_n, ccount};
    x_cv     = ((item_q.kind == pboe_pkg::KIND_CNT) & c_ok) ? ccount : '0;
  end

  always_comb begin
    if ((state_q == ST_WALK) & wv_q) begin
      cnt_we = 1'b1;
      cnt_wa = wa_q;
      cnt_wd = w_cnt_wd;
    end else begin
      cnt_we = exec_go & x_cnt_we;
      cnt_wa = item_q.idx[CW-1:0];
      cnt_wd = x_cnt_wd;
    end
  end

  always_comb begin
    state_d     = state_q;
    wc_d        = wc_q;
    wv_d        = 1'b0;
    wa_d        = wa_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        wc_d = '0;
        if (in_acc) begin
          if ((action_i == pboe_pkg::ACT_BEGIN) || (action_i == pboe_pkg::ACT_END)) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_WALK: begin
        if (walk_rd) begin
          wc_d = wc_q + WCW'(1);
          wv_d = 1'b1;
          wa_d = wc_q[CW-1:0];
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wc_q        <= '0;
      wv_q        <= 1'b0;
      wa_q        <= '0;
      out_valid_q <= 1'b0;
      ro_mask_q   <= '0;
      down_mask_q <= '0;
      in_vld_q    <= '{default: 1'b0};
      out_vld_q   <= '{default: 1'b0};
      cnt_vld_q   <= '{default: 1'b0};
    end else begin
      state_q     <= state_d;
      wc_q        <= wc_d;
      wv_q        <= wv_d;
      wa_q        <= wa_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        if (paddr[2] == pboe_pkg::REG_DOWN_MASK) begin
          down_mask_q <= pwdata;
        end else begin
          ro_mask_q <= pwdata;
        end
      end
      if (exec_go & in_we) begin
        in_vld_q[in_wa] <= 1'b1;
      end
      if (exec_go & out_we) begin
        out_vld_q[out_wa] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_vld_q[cnt_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= '{action: action_i, kind: operand_kind_i, idx: operand_index_i,
                  bit_in: bit_in_i, bits: input_bits_i, edges: input_edges_i};
    end
    if (exec_go) begin
      bit_value_q     <= x_bv;
      error_q         <= x_err;
      output_byte_q   <= x_ob;
      counter_value_q <= x_cv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_rd_q  <= in_mem[in_ra];
      in_rv_q  <= in_vld_q[in_ra];
      out_rd_q <= out_mem[out_ra];
      out_rv_q <= out_vld_q[out_ra];
    end
    if (exec_go & in_we) begin
      in_mem[in_wa] <= in_wd;
    end
    if (exec_go & out_we) begin
      out_mem[out_wa] <= out_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_ra];
      cnt_rv_q <= cnt_vld_q[cnt_ra];
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bit_value_o     = bit_value_q;
  assign error_o         = error_q;
  assign output_byte_o   = output_byte_q;
  assign counter_value_o = counter_value_q;

endmodule

// ===== src/pboe_checker.sv =====
// ----------------------------------------------------------------------------
// pboe_checker
// Port-level checks of the PLC bit-operand engine, bound to the top level.
// ----------------------------------------------------------------------------
module pboe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        bit_value_o,
  input logic        error_o,
  input logic [7:0]  output_byte_o,
  input logic [31:0] counter_value_o
);

  // A stalled result word keeps its counter value, output byte and error flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(counter_value_o) &&
                                    $stable(output_byte_o) && $stable(error_o))
    else $error("result word changed while stalled");

  // Only one command is in flight, so no word is taken right after another.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command accepted while another is in flight");

  // A rejected command reports no bit and no output byte.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> !bit_value_o && (output_byte_o == 8'd0))
    else $error("error result carries data");

  // Only the read-out command fills the output byte, and it gives no bit.
  a_byte_no_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (output_byte_o != 8'd0) |-> !bit_value_o && !error_o)
    else $error("output byte together with a bit result");

endmodule

bind plc_bit_operand_engine_unit pboe_checker u_pboe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .bit_value_o     (bit_value_o),
  .error_o         (error_o),
  .output_byte_o   (output_byte_o),
  .counter_value_o (counter_value_o)
);
